// ===== sv/aes_block_cipher_macros.svh =====
// Assertion macros for the AES block cipher checker
`ifndef AES_BLOCK_CIPHER_MACROS_SVH
`define AES_BLOCK_CIPHER_MACROS_SVH
// implication check under reset
`define AES_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aes check failed");
// next-cycle implication check under reset
`define AES_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aes check failed");
`endif

// ===== sv/aes_pkg.sv =====
// Shared types, constants and GF(2^8) helpers for the AES block cipher
package aes_pkg;

  localparam int unsigned RkDepth = 60;
  localparam int unsigned RkAw    = 6;

  typedef enum logic [2:0] {
    CFG_KEY_SIZE = 3'd0,
    CFG_KEY_W0   = 3'd1,
    CFG_KEY_W1   = 3'd2,
    CFG_KEY_W2   = 3'd3,
    CFG_KEY_W3   = 3'd4
  } cfg_idx_t;

  // round unit operation select
  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_ENC     = 3'd1,
    OP_ENC_FIN = 3'd2,
    OP_DEC     = 3'd3,
    OP_DEC_FIN = 3'd4
  } op_t;

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[x];
  endfunction

  function automatic logic [7:0] isbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    isbox = t[x];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage

// ===== sv/aes_block_cipher.sv =====
// AES block cipher top level: config, key store, round sequencer
// One 128-bit block per transaction, encrypt or decrypt, 128/192/256-bit key.
// start is taken while busy is low; busy stays high until the result is shown.
// Each round key is read from the key store as four 32-bit words, one
// address per S_FETCH step; the last word is shifted in during S_ROUND and the
// shared round unit then applies the round from S_ROUND. The key size selects
// 10, 12 or 14 rounds.
// busy is already low in the result cycle, so the next start can be taken at
// the edge that ends it; no new block is taken while one is in flight. After
// reset or any key register write, the next start first runs key expansion,
// which writes one round-key word per cycle between the S_EXP_GO launch state
// and the hand-off to S_FETCH. out_valid pulses for one cycle with the result;
// the receiver cannot stall it.
module aes_block_cipher import aes_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_data,
  input  logic          start,
  output logic          busy,
  input  logic          in_kind,
  input  logic [63:0]   in_block_hi,
  input  logic [63:0]   in_block_lo,
  output logic          out_valid,
  output logic [63:0]   out_result_hi,
  output logic [63:0]   out_result_lo
);

  typedef enum logic [2:0] {S_IDLE, S_EXP_GO, S_EXP, S_FETCH, S_ROUND} state_t;

  state_t        state_r;
  logic [1:0]    ksize_r;
  logic [63:0]   kw_r [4];
  logic          pend_r;
  logic          dec_r;
  logic [127:0]  st_r;
  logic [127:0]  rk_r;
  logic [3:0]    rnd_r;      // round number being applied
  logic [3:0]    step_r;     // round-key counter: 0 .. nr
  logic [1:0]    col_r;
  logic          rd_pend_r;
  logic [3:0]    nr;
  logic [31:0]   mem [RkDepth];
  logic [31:0]   rd_data_r;
  logic [RkAw-1:0] rd_addr;
  logic          exp_go, exp_done, exp_we;
  logic [RkAw-1:0] exp_addr;
  logic [31:0]   exp_data, imix;
  logic [31:0]   rk_word;
  op_t           op;
  logic [127:0]  rnd_res;

  always_comb begin
    unique case (ksize_r)
      2'd0:    nr = 4'd10;
      2'd1:    nr = 4'd12;
      default: nr = 4'd14;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ksize_r <= 2'd0;
      for (int i = 0; i < 4; i++) kw_r[i] <= 64'h0;
      pend_r  <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KEY_SIZE: begin ksize_r <= cfg_data[1:0]; pend_r <= 1'b1; end
          CFG_KEY_W0:   begin kw_r[0] <= cfg_data; pend_r <= 1'b1; end
          CFG_KEY_W1:   begin kw_r[1] <= cfg_data; pend_r <= 1'b1; end
          CFG_KEY_W2:   begin kw_r[2] <= cfg_data; pend_r <= 1'b1; end
          CFG_KEY_W3:   begin kw_r[3] <= cfg_data; pend_r <= 1'b1; end
          default: ;
        endcase
      end else if (state_r == S_EXP_GO) begin
        pend_r <= 1'b0;
      end
    end
  end

  assign exp_go = (state_r == S_EXP_GO);

  aes_key_exp u_exp (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (exp_go),
    .key_size (ksize_r),
    .key      ({kw_r[0], kw_r[1], kw_r[2], kw_r[3]}),
    .done     (exp_done),
    .wr_en    (exp_we),
    .wr_addr  (exp_addr),
    .wr_data  (exp_data)
  );

  // round-key word for this round and column
  assign rd_addr = RkAw'({step_r, col_r});

  // key store: written by expansion, read one word per cycle
  always_ff @(posedge clk) begin
    if (exp_we) mem[exp_addr] <= exp_data;
    rd_data_r <= mem[rd_addr];
  end

  aes_inv_mix u_imix (.w(rd_data_r), .r(imix));

  // middle decrypt rounds use InvMixColumns of the key
  assign rk_word = (dec_r && rnd_r != 4'd0 && rnd_r != nr) ? imix : rd_data_r;

  always_comb begin
    if (rnd_r == 4'd0) op = OP_ADD;
    else if (rnd_r == nr) op = dec_r ? OP_DEC_FIN : OP_ENC_FIN;
    else op = dec_r ? OP_DEC : OP_ENC;
  end

  aes_round u_round (.op(op), .st(st_r), .rk(rk_r), .res(rnd_res));

  // sequencer
  always_ff @(posedge clk) begin
    out_valid <= 1'b0;
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_pend_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            dec_r  <= in_kind;
            st_r   <= {in_block_hi, in_block_lo};
            state_r <= pend_r ? S_EXP_GO : S_FETCH;
            col_r  <= 2'd0;
            rnd_r  <= 4'd0;
            rd_pend_r <= 1'b0;
            step_r <= in_kind ? nr : 4'd0;
          end
        end
        S_EXP_GO: state_r <= S_EXP;
        S_EXP: begin
          if (exp_done) begin
            state_r <= S_FETCH;
            col_r  <= 2'd0;
            step_r <= dec_r ? nr : 4'd0;
          end
        end
        S_FETCH: begin
          // read data is registered: it lands the cycle after its address is issued
          rd_pend_r <= 1'b1;
          if (rd_pend_r) begin
            rk_r <= {rk_r[95:0], rk_word};
          end
          col_r <= col_r + 2'd1;
          if (col_r == 2'd3) begin
            state_r <= S_ROUND;
          end
        end
        S_ROUND: begin
          if (rd_pend_r) begin
            rk_r <= {rk_r[95:0], rk_word};
            rd_pend_r <= 1'b0;
          end else begin
            st_r <= rnd_res;
            if (rnd_r == nr) begin
              out_valid     <= 1'b1;
              out_result_hi <= rnd_res[127:64];
              out_result_lo <= rnd_res[63:0];
              state_r       <= S_IDLE;
            end else begin
              rnd_r   <= rnd_r + 4'd1;
              step_r  <= dec_r ? step_r - 4'd1 : step_r + 4'd1;
              col_r   <= 2'd0;
              state_r <= S_FETCH;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== sv/aes_key_exp.sv =====
// Key expansion sequencer: one round-key word per cycle into the key store
module aes_key_exp import aes_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [1:0]       key_size,
  input  logic [255:0]     key,
  output logic             done,
  output logic             wr_en,
  output logic [RkAw-1:0]  wr_addr,
  output logic [31:0]      wr_data
);

  // last eight words form a sliding window: win_r[0] is word i-1
  logic [31:0]     win_r [8];
  logic [31:0]     win_nxt [8];
  logic [RkAw-1:0] idx_r, idx_nxt;
  logic [2:0]      ph_r, ph_nxt;       // i mod nk
  logic [7:0]      rcon_r, rcon_nxt;
  logic            run_r, run_nxt;
  logic [3:0]      nk;
  logic [RkAw-1:0] total;
  logic [31:0]     tmp, wnew, wprev_nk;

  always_comb begin
    unique case (key_size)
      2'd0:    nk = 4'd4;
      2'd1:    nk = 4'd6;
      default: nk = 4'd8;
    endcase
    total = RkAw'(4 * 11) + RkAw'({nk - 4'd4, 2'b00});
  end

  // word i-nk sits at window slot nk-1
  always_comb begin
    wprev_nk = win_r[nk[2:0] - 3'd1];
    tmp = win_r[0];
    if (ph_r == 3'd0) begin
      tmp = sub_word({win_r[0][23:0], win_r[0][31:24]}) ^ {rcon_r, 24'h0};
    end else if (nk == 4'd8 && ph_r == 3'd4) begin
      tmp = sub_word(win_r[0]);
    end
    wnew = wprev_nk ^ tmp;
  end

  always_comb begin
    win_nxt  = win_r;
    idx_nxt  = idx_r;
    ph_nxt   = ph_r;
    rcon_nxt = rcon_r;
    run_nxt  = run_r;
    wr_en    = 1'b0;
    wr_addr  = idx_r;
    wr_data  = wnew;
    if (go) begin
      // load key words: word j into slot nk-1-j
      for (int j = 0; j < 8; j++) begin
        win_nxt[j] = 32'h0;
      end
      for (int j = 0; j < 8; j++) begin
        if (4'(j) < nk) begin
          win_nxt[nk[2:0] - 3'd1 - 3'(j)] = key[255 - 32*j -: 32];
        end
      end
      idx_nxt  = '0;
      ph_nxt   = 3'd0;
      rcon_nxt = 8'h01;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      wr_en = 1'b1;
      if (idx_r < RkAw'(nk)) begin
        wr_data = win_r[nk[2:0] - 3'd1 - idx_r[2:0]];
      end else begin
        for (int j = 7; j > 0; j--) begin
          win_nxt[j] = win_r[j-1];
        end
        win_nxt[0] = wnew;
        ph_nxt = (ph_r == nk[2:0] - 3'd1) ? 3'd0 : ph_r + 3'd1;
        if (ph_r == 3'd0) begin
          rcon_nxt = xtime(rcon_r);
        end
      end
      if (idx_r == total - RkAw'(1)) begin
        run_nxt = 1'b0;
      end
      idx_nxt = idx_r + RkAw'(1);
    end
  end

  assign done = !run_r && !go;

  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    idx_r  <= idx_nxt;
    ph_r   <= ph_nxt;
    rcon_r <= rcon_nxt;
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
    end
  end

endmodule

// ===== sv/aes_round.sv =====
// Shared AES round unit: one full round per cycle, forward or inverse
module aes_round import aes_pkg::*; (
  input  op_t          op,
  input  logic [127:0] st,
  input  logic [127:0] rk,
  output logic [127:0] res
);

  logic [7:0] s  [16];
  logic [7:0] t  [16];
  logic [7:0] m  [16];
  logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, y0, y1, y2, y3, z0, z1, z2, z3;
  logic       inv;

  assign inv = (op == OP_DEC) || (op == OP_DEC_FIN);

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = st[127 - 8*i -: 8];
    end
    // sub bytes with row shift
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          t[4*((c + r) % 4) + r] = isbox(s[4*c + r]);
        end else begin
          t[4*c + r] = sbox(s[4*((c + r) % 4) + r]);
        end
      end
    end
    // column mix
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
      y0 = xtime(x0); y1 = xtime(x1); y2 = xtime(x2); y3 = xtime(x3);
      z0 = xtime(y0); z1 = xtime(y1); z2 = xtime(y2); z3 = xtime(y3);
      if (inv) begin
        // 14 11 13 9
        m[4*c]   = (z0^y0^x0) ^ (z1^x1^a1) ^ (z2^y2^a2) ^ (z3^a3);
        m[4*c+1] = (z0^a0) ^ (z1^y1^x1) ^ (z2^x2^a2) ^ (z3^y3^a3);
        m[4*c+2] = (z0^y0^a0) ^ (z1^a1) ^ (z2^y2^x2) ^ (z3^x3^a3);
        m[4*c+3] = (z0^x0^a0) ^ (z1^y1^a1) ^ (z2^a2) ^ (z3^y3^x3);
      end else begin
        m[4*c]   = x0 ^ (x1^a1) ^ a2 ^ a3;
        m[4*c+1] = a0 ^ x1 ^ (x2^a2) ^ a3;
        m[4*c+2] = a0 ^ a1 ^ x2 ^ (x3^a3);
        m[4*c+3] = (x0^a0) ^ a1 ^ a2 ^ x3;
      end
    end
    unique case (op)
      OP_ADD: res = st ^ rk;
      OP_ENC, OP_DEC: begin
        for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = m[i];
        res = res ^ rk;
      end
      OP_ENC_FIN, OP_DEC_FIN: begin
        for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = t[i];
        res = res ^ rk;
      end
      default: res = st ^ rk;
    endcase
  end

endmodule

// ===== sv/aes_inv_mix.sv =====
// InvMixColumns on one 32-bit word, for equivalent-inverse round keys
module aes_inv_mix import aes_pkg::*; (
  input  logic [31:0] w,
  output logic [31:0] r
);

  logic [7:0] a [4];
  logic [7:0] x [4];
  logic [7:0] y [4];
  logic [7:0] z [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      a[k] = w[31 - 8*k -: 8];
      x[k] = xtime(a[k]);
      y[k] = xtime(x[k]);
      z[k] = xtime(y[k]);
    end
    r[31:24] = (z[0]^y[0]^x[0]) ^ (z[1]^x[1]^a[1]) ^ (z[2]^y[2]^a[2]) ^ (z[3]^a[3]);
    r[23:16] = (z[0]^a[0]) ^ (z[1]^y[1]^x[1]) ^ (z[2]^x[2]^a[2]) ^ (z[3]^y[3]^a[3]);
    r[15:8]  = (z[0]^y[0]^a[0]) ^ (z[1]^a[1]) ^ (z[2]^y[2]^x[2]) ^ (z[3]^x[3]^a[3]);
    r[7:0]   = (z[0]^x[0]^a[0]) ^ (z[1]^y[1]^a[1]) ^ (z[2]^a[2]) ^ (z[3]^y[3]^x[3]);
  end

endmodule

// ===== sv/aes_block_cipher_checker.sv =====
// Port-level checker for the AES block cipher, bound to the top level
`include "aes_block_cipher_macros.svh"
module aes_block_cipher_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // accepted start makes the block busy
  `AES_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  // a result is a single-cycle strobe
  `AES_ASSERT_NEXT(a_strobe_one, out_valid, !out_valid)
  // result comes after busy ends
  `AES_ASSERT_IMP(a_valid_idle, out_valid, !busy)
  // a result only follows busy
  `AES_ASSERT_IMP(a_valid_after, out_valid, $past(busy))

endmodule

bind aes_block_cipher aes_block_cipher_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid)
);
